### rtl/mrac_pkg.sv
// Shared types and constants of the memory region access checker.
// Depends on nothing; the other files of the block, but for mrac_channels, refer to it by scoped names.
`timescale 1ns / 1ps

package mrac_pkg;

   // Operation codes of a request.
   localparam logic [1:0] OP_CHECK  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Result status codes.
   localparam logic [3:0] STATUS_OK         = 4'd0;
   localparam logic [3:0] STATUS_NO_REGION  = 4'd1;
   localparam logic [3:0] STATUS_CROSSES    = 4'd2;
   localparam logic [3:0] STATUS_UNREADABLE = 4'd3;
   localparam logic [3:0] STATUS_READ_ONLY  = 4'd4;
   localparam logic [3:0] STATUS_MMIO_SIZE  = 4'd5;
   localparam logic [3:0] STATUS_MMIO_ALIGN = 4'd6;
   localparam logic [3:0] STATUS_FULL       = 4'd7;
   localparam logic [3:0] STATUS_BAD_RANGE  = 4'd8;
   localparam logic [3:0] STATUS_OVERLAP    = 4'd9;

   localparam logic [1:0] KIND_MMIO = 2'd2;

   // Bit positions in the permission field.
   localparam int PERM_READ_BIT  = 0;
   localparam int PERM_WRITE_BIT = 1;
   localparam int PERM_EXEC_BIT  = 2;

   typedef struct packed {
      logic [31:0] region_start;
      logic [31:0] region_end;
      logic [1:0]  kind;
      logic [2:0]  perm;
   } region_entry_type;

   // What the final decision of a check looks at.
   typedef struct packed {
      region_entry_type entry;
      logic [31:0]      address;
      logic [3:0]       access_size;
      logic             write_access;
   } decide_in_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DECIDE,
      ST_DONE
   } state_type;

endpackage

### rtl/mrac_channels.sv
// Handshake interfaces for the request and response channels of the checker.
// Depends on nothing; payload widths are fixed.
`timescale 1ns / 1ps

interface mrac_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] address;
   logic [31:0] region_end;
   logic [3:0]  access_size;
   logic        write_access;
   logic [1:0]  region_kind;
   logic        can_read;
   logic        can_write;
   logic        can_execute;

   modport source (
      output valid, op, address, region_end, access_size, write_access,
             region_kind, can_read, can_write, can_execute,
      input  ready
   );
   modport sink (
      input  valid, op, address, region_end, access_size, write_access,
             region_kind, can_read, can_write, can_execute,
      output ready
   );
endinterface

interface mrac_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [2:0] hit_index;
   logic [3:0] used_count;

   modport source (output valid, status, hit_index, used_count, input ready);
   modport sink (input valid, status, hit_index, used_count, output ready);
endinterface

### rtl/mrac_region_mem.sv
// Region table memory: one write port, one read port, registered read data.
// Depends on mrac_pkg for the entry type.
`timescale 1ns / 1ps

module mrac_region_mem #(
   parameter int DEPTH = 8,
   parameter int IW    = 3
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [IW-1:0]             rd_addr,
   output mrac_pkg::region_entry_type rd_data,
   input  logic                      wr_en,
   input  logic [IW-1:0]             wr_addr,
   input  mrac_pkg::region_entry_type wr_data
);

   mrac_pkg::region_entry_type mem [DEPTH];
   mrac_pkg::region_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mrac_decide.sv
// Final verdict of a check against the region that the table walk found.
// Depends on mrac_pkg for the input struct and the status codes.
`timescale 1ns / 1ps

module mrac_decide (
   input  mrac_pkg::decide_in_type dec,
   output logic [3:0]              status
);

   logic [32:0] access_top;
   logic        crosses;
   logic        size_ok;
   logic        misaligned;

   // The sum is kept at 33 bits so an access near the top of the space does not wrap.
   assign access_top = {1'b0, dec.address} + {29'd0, dec.access_size};
   assign crosses    = access_top > {1'b0, dec.entry.region_end};
   assign size_ok    = (dec.access_size == 4'd1) || (dec.access_size == 4'd2) ||
                       (dec.access_size == 4'd4) || (dec.access_size == 4'd8);
   assign misaligned = (dec.address[3:0] & (dec.access_size - 4'd1)) != 4'd0;

   always_comb begin
      if (crosses) begin
         status = mrac_pkg::STATUS_CROSSES;
      end else if (!dec.entry.perm[mrac_pkg::PERM_READ_BIT]) begin
         status = mrac_pkg::STATUS_UNREADABLE;
      end else if (dec.write_access && !dec.entry.perm[mrac_pkg::PERM_WRITE_BIT]) begin
         status = mrac_pkg::STATUS_READ_ONLY;
      end else if (dec.entry.kind == mrac_pkg::KIND_MMIO && !size_ok) begin
         status = mrac_pkg::STATUS_MMIO_SIZE;
      end else if (dec.entry.kind == mrac_pkg::KIND_MMIO && misaligned) begin
         status = mrac_pkg::STATUS_MMIO_ALIGN;
      end else begin
         status = mrac_pkg::STATUS_OK;
      end
   end

endmodule

### rtl/memory_region_access_checker_top.sv
// Top level of the memory region access checker: sequencer, table walk, response register.
// Depends on mrac_pkg, mrac_channels, mrac_region_mem and mrac_decide.
`timescale 1ns / 1ps

// The checker keeps up to MAX_REGIONS regions in a one-port-read, one-port-write
// memory and handles one request at a time. Clear, the unused op code, a check of
// an empty table, and an insert that is rejected as full or bad range, or that goes
// into an empty table, finish without a table walk: the sequencer goes from idle
// straight to its final state, which loads the response register. Check and other
// inserts walk the stored regions one memory read per cycle, pipelined against the
// compare; the end of the walk is seen in the cycle after the last compare. The walk
// stops at the first hit: an insert that overlaps a slot goes to the final state,
// and a check that hits a slot passes through the decide state for its verdict.
// The sequencer waits in its final state while the previous response is still held
// in the output register; a new request is accepted while the last response still
// waits there.
module memory_region_access_checker_top #(
   parameter int MAX_REGIONS = 8
) (
   input  logic            clock,
   input  logic            reset,
   mrac_req_if.sink        req_chan,
   mrac_rsp_if.source      rsp_chan
);

   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   mrac_pkg::state_type state_ff, state_in;

   // Latched request.
   logic [1:0]  op_ff, op_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] rend_ff, rend_in;
   logic [3:0]  size_ff, size_in;
   logic        wr_ff, wr_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  perm_ff, perm_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pslot_ff, pslot_in;

   mrac_pkg::region_entry_type hit_entry_ff, hit_entry_in;
   logic [3:0]    res_status_ff, res_status_in;
   logic [IW-1:0] res_slot_ff, res_slot_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_status_ff, rsp_status_in;
   logic [2:0] rsp_hit_ff, rsp_hit_in;
   logic [3:0] rsp_used_ff, rsp_used_in;

   logic                       mem_rd_en;
   logic [IW-1:0]              mem_rd_addr;
   mrac_pkg::region_entry_type mem_rd_data;
   logic                       mem_wr_en;
   logic [IW-1:0]              mem_wr_addr;
   mrac_pkg::region_entry_type mem_wr_data;

   mrac_pkg::decide_in_type dec;
   logic [3:0]              dec_status;

   logic req_fire;
   logic out_free;
   logic table_full;
   logic in_region;
   logic overlaps;
   logic walk_hit;
   logic walk_end;

   assign req_chan.ready = (state_ff == mrac_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign table_full     = (count_ff == CW'(MAX_REGIONS));

   assign in_region = (addr_ff >= mem_rd_data.region_start) &&
                      (addr_ff < mem_rd_data.region_end);
   assign overlaps  = !((rend_ff <= mem_rd_data.region_start) ||
                        (addr_ff >= mem_rd_data.region_end));
   assign walk_hit  = pend_ff && ((op_ff == mrac_pkg::OP_CHECK) ? in_region : overlaps);
   assign walk_end  = !pend_ff && (iss_ff == count_ff);

   // Reads are issued only while some slot is still unvisited.
   assign mem_rd_en   = (state_ff == mrac_pkg::ST_WALK) && !walk_hit && (iss_ff < count_ff);
   assign mem_rd_addr = iss_ff[IW-1:0];

   mrac_region_mem #(
      .DEPTH (MAX_REGIONS),
      .IW    (IW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign dec.entry        = hit_entry_ff;
   assign dec.address      = addr_ff;
   assign dec.access_size  = size_ff;
   assign dec.write_access = wr_ff;

   mrac_decide u_decide (
      .dec    (dec),
      .status (dec_status)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrac_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.op)
                  mrac_pkg::OP_CHECK: begin
                     state_in = (count_ff == '0) ? mrac_pkg::ST_DONE : mrac_pkg::ST_WALK;
                  end
                  mrac_pkg::OP_INSERT: begin
                     if (table_full || (req_chan.address >= req_chan.region_end) ||
                         (count_ff == '0)) begin
                        state_in = mrac_pkg::ST_DONE;
                     end else begin
                        state_in = mrac_pkg::ST_WALK;
                     end
                  end
                  default: state_in = mrac_pkg::ST_DONE;
               endcase
            end
         end
         mrac_pkg::ST_WALK: begin
            if (walk_hit) begin
               state_in = (op_ff == mrac_pkg::OP_CHECK) ? mrac_pkg::ST_DECIDE
                                                        : mrac_pkg::ST_DONE;
            end else if (walk_end) begin
               state_in = mrac_pkg::ST_DONE;
            end
         end
         mrac_pkg::ST_DECIDE: state_in = mrac_pkg::ST_DONE;
         mrac_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mrac_pkg::ST_IDLE;
            end
         end
         default: state_in = mrac_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      rend_in       = rend_ff;
      size_in       = size_ff;
      wr_in         = wr_ff;
      kind_in       = kind_ff;
      perm_in       = perm_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      pend_in       = pend_ff;
      pslot_in      = pslot_ff;
      hit_entry_in  = hit_entry_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_used_in   = rsp_used_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[IW-1:0];
      mem_wr_data.region_start = addr_ff;
      mem_wr_data.region_end   = rend_ff;
      mem_wr_data.kind         = kind_ff;
      mem_wr_data.perm         = perm_ff;

      case (state_ff)
         mrac_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_chan.op;
               addr_in     = req_chan.address;
               rend_in     = req_chan.region_end;
               size_in     = req_chan.access_size;
               wr_in       = req_chan.write_access;
               kind_in     = req_chan.region_kind;
               perm_in     = {req_chan.can_execute, req_chan.can_write, req_chan.can_read};
               iss_in      = '0;
               pend_in     = 1'b0;
               res_slot_in = '0;
               case (req_chan.op)
                  mrac_pkg::OP_CHECK: res_status_in = mrac_pkg::STATUS_NO_REGION;
                  mrac_pkg::OP_INSERT: begin
                     if (table_full) begin
                        res_status_in = mrac_pkg::STATUS_FULL;
                     end else if (req_chan.address >= req_chan.region_end) begin
                        res_status_in = mrac_pkg::STATUS_BAD_RANGE;
                     end else begin
                        // Into an empty table nothing can overlap: write at once.
                        res_status_in = mrac_pkg::STATUS_OK;
                        if (count_ff == '0) begin
                           mem_wr_en                = 1'b1;
                           mem_wr_data.region_start = req_chan.address;
                           mem_wr_data.region_end   = req_chan.region_end;
                           mem_wr_data.kind         = req_chan.region_kind;
                           mem_wr_data.perm         = {req_chan.can_execute,
                                                       req_chan.can_write,
                                                       req_chan.can_read};
                           count_in                 = count_ff + CW'(1);
                        end
                     end
                  end
                  mrac_pkg::OP_CLEAR: begin
                     count_in      = '0;
                     res_status_in = mrac_pkg::STATUS_OK;
                  end
                  default: res_status_in = mrac_pkg::STATUS_OK;
               endcase
            end
         end
         mrac_pkg::ST_WALK: begin
            pend_in = mem_rd_en;
            if (mem_rd_en) begin
               pslot_in = iss_ff[IW-1:0];
               iss_in   = iss_ff + CW'(1);
            end
            if (walk_hit) begin
               res_slot_in  = pslot_ff;
               hit_entry_in = mem_rd_data;
               if (op_ff == mrac_pkg::OP_INSERT) begin
                  res_status_in = mrac_pkg::STATUS_OVERLAP;
               end
            end else if (walk_end) begin
               if (op_ff == mrac_pkg::OP_CHECK) begin
                  res_status_in = mrac_pkg::STATUS_NO_REGION;
                  res_slot_in   = '0;
               end else begin
                  // No overlap found: append at the first free slot.
                  mem_wr_en     = 1'b1;
                  res_status_in = mrac_pkg::STATUS_OK;
                  res_slot_in   = count_ff[IW-1:0];
                  count_in      = count_ff + CW'(1);
               end
            end
         end
         mrac_pkg::ST_DECIDE: begin
            res_status_in = dec_status;
         end
         mrac_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hit_in    = 3'(res_slot_ff);
               rsp_used_in   = 4'(count_ff);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrac_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      rend_ff       <= rend_in;
      size_ff       <= size_in;
      wr_ff         <= wr_in;
      kind_ff       <= kind_in;
      perm_ff       <= perm_in;
      iss_ff        <= iss_in;
      pslot_ff      <= pslot_in;
      hit_entry_ff  <= hit_entry_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.hit_index  = rsp_hit_ff;
   assign rsp_chan.used_count = rsp_used_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_REGIONS))
      else $error("region count exceeds table depth");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !table_full)
      else $error("table written while full");

   a_no_rw_same_slot: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("read and write of the same slot in one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != mrac_pkg::ST_IDLE))
      else $error("sequencer idle right after accepting a request");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == mrac_pkg::ST_DONE))
      else $error("response raised outside the done state");
`endif

endmodule

### tb/mrac_region_verdict_checker.sv
// Response checker for the memory region access checker: predicts every verdict and compares it.
// Depends on mrac_pkg and the request and response interfaces in mrac_channels.
`timescale 1ns / 1ps

module mrac_region_verdict_checker #(
   parameter int REGION_SLOTS = 8
) (
   input  logic clock,
   input  logic reset,
   mrac_req_if  req_mon,
   mrac_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   awaiting_count
);

   typedef struct packed {
      logic [3:0] status;
      logic [2:0] hit_index;
      logic [3:0] used_count;
   } verdict_type;

   // Shadow copy of the region table.
   logic [31:0] start_tbl[REGION_SLOTS];
   logic [31:0] end_tbl[REGION_SLOTS];
   logic [1:0]  kind_tbl[REGION_SLOTS];
   logic [2:0]  perm_tbl[REGION_SLOTS];
   int          entry_total;

   verdict_type pending_verdicts[$];
   int          failures;

   function automatic verdict_type predict_verdict(
      input logic [1:0]  op,
      input logic [31:0] address,
      input logic [31:0] region_end,
      input logic [3:0]  access_size,
      input logic        write_access,
      input logic [1:0]  region_kind,
      input logic [2:0]  perm
   );
      verdict_type v;
      int          found;
      logic [32:0] reach;
      v = '{status: mrac_pkg::STATUS_OK, hit_index: 3'd0, used_count: 4'd0};
      found = -1;
      case (op)
         mrac_pkg::OP_CHECK: begin
            for (int i = 0; i < entry_total; i++) begin
               if (found < 0 && address >= start_tbl[i] && address < end_tbl[i]) begin
                  found = i;
               end
            end
            if (found < 0) begin
               v.status = mrac_pkg::STATUS_NO_REGION;
            end else begin
               v.hit_index = 3'(found);
               // The end of the access is computed one bit wider so it cannot wrap.
               reach = {1'b0, address} + 33'(access_size);
               if (reach > {1'b0, end_tbl[found]}) begin
                  v.status = mrac_pkg::STATUS_CROSSES;
               end else if (!perm_tbl[found][mrac_pkg::PERM_READ_BIT]) begin
                  v.status = mrac_pkg::STATUS_UNREADABLE;
               end else if (write_access && !perm_tbl[found][mrac_pkg::PERM_WRITE_BIT]) begin
                  v.status = mrac_pkg::STATUS_READ_ONLY;
               end else if (kind_tbl[found] == mrac_pkg::KIND_MMIO) begin
                  if (access_size != 4'd1 && access_size != 4'd2 &&
                      access_size != 4'd4 && access_size != 4'd8) begin
                     v.status = mrac_pkg::STATUS_MMIO_SIZE;
                  end else if ((address & (32'(access_size) - 32'd1)) != 32'd0) begin
                     v.status = mrac_pkg::STATUS_MMIO_ALIGN;
                  end
               end
            end
         end
         mrac_pkg::OP_INSERT: begin
            if (entry_total >= REGION_SLOTS) begin
               v.status = mrac_pkg::STATUS_FULL;
            end else if (address >= region_end) begin
               v.status = mrac_pkg::STATUS_BAD_RANGE;
            end else begin
               for (int i = 0; i < entry_total; i++) begin
                  if (found < 0 && !(region_end <= start_tbl[i] || address >= end_tbl[i])) begin
                     found = i;
                  end
               end
               if (found >= 0) begin
                  v.status    = mrac_pkg::STATUS_OVERLAP;
                  v.hit_index = 3'(found);
               end else begin
                  start_tbl[entry_total] = address;
                  end_tbl[entry_total]   = region_end;
                  kind_tbl[entry_total]  = region_kind;
                  perm_tbl[entry_total]  = perm;
                  v.hit_index = 3'(entry_total);
                  entry_total = entry_total + 1;
               end
            end
         end
         mrac_pkg::OP_CLEAR: begin
            entry_total = 0;
         end
         default: begin
         end
      endcase
      v.used_count = 4'(entry_total);
      return v;
   endfunction

   task automatic note_failure(input string msg);
      if (failures < 10) begin
         $display("[%0t] %s", $realtime, msg);
      end
      failures++;
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (reset) begin
         entry_total = 0;
         pending_verdicts.delete();
      end else begin
         // Retire a response before taking a new request so a response can never
         // be matched against the request accepted on the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{status: rsp_mon.status, hit_index: rsp_mon.hit_index,
                    used_count: rsp_mon.used_count};
            if (pending_verdicts.size() == 0) begin
               note_failure($sformatf("unexpected response: status %0d hit %0d count %0d",
                                      got.status, got.hit_index, got.used_count));
            end else begin
               want = pending_verdicts.pop_front();
               if (got.status !== want.status || got.hit_index !== want.hit_index ||
                   got.used_count !== want.used_count) begin
                  note_failure($sformatf(
                     "mismatch: status %0d/%0d hit %0d/%0d count %0d/%0d (expected/actual)",
                     want.status, got.status, want.hit_index, got.hit_index,
                     want.used_count, got.used_count));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_verdicts.push_back(predict_verdict(
               req_mon.op, req_mon.address, req_mon.region_end, req_mon.access_size,
               req_mon.write_access, req_mon.region_kind,
               {req_mon.can_execute, req_mon.can_write, req_mon.can_read}));
         end
      end
      mismatch_count <= failures;
      awaiting_count <= pending_verdicts.size();
   end

endmodule

### tb/memory_region_access_checker_top_tb.sv
// Testbench top for the memory region access checker: clock, reset, request stimulus and verdict.
// Depends on mrac_pkg, mrac_channels, the checker RTL and mrac_region_verdict_checker.
`timescale 1ns / 1ps

module memory_region_access_checker_top_tb;

   localparam int          REGION_SLOTS   = 8;
   localparam int          RANDOM_ITEMS   = 1400;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          SETTLE_CYCLES  = 30;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam logic [1:0]  KIND_RESERVED  = 2'd0;
   localparam logic [1:0]  KIND_RAM       = 2'd1;
   localparam logic [1:0]  KIND_SPARE     = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] address;
      logic [31:0] region_end;
      logic [3:0]  access_size;
      logic        write_access;
      logic [1:0]  region_kind;
      logic        can_read;
      logic        can_write;
      logic        can_execute;
   } request_type;

   typedef struct {
      logic [31:0] lo;
      logic [31:0] hi;
   } span_type;

   logic clock = 1'b0;
   logic reset;
   int   send_gap_pct;
   int   stall_pct;
   int   error_total;
   int   awaiting;
   int   quiet_cycles;
   int   sent;

   // Regions the generator has tried to insert since the last clear.
   span_type layout[$];

   mrac_req_if req_chan();
   mrac_rsp_if rsp_chan();

   memory_region_access_checker_top #(
      .MAX_REGIONS(REGION_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mrac_region_verdict_checker #(
      .REGION_SLOTS(REGION_SLOTS)
   ) verdict_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (error_total),
      .awaiting_count (awaiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input request_type item);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= item.op;
      req_chan.address      <= item.address;
      req_chan.region_end   <= item.region_end;
      req_chan.access_size  <= item.access_size;
      req_chan.write_access <= item.write_access;
      req_chan.region_kind  <= item.region_kind;
      req_chan.can_read     <= item.can_read;
      req_chan.can_write    <= item.can_write;
      req_chan.can_execute  <= item.can_execute;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic check_access(input logic [31:0] address, input logic [3:0] access_size,
                               input logic write_access);
      request_type item;
      item              = '0;
      item.op           = mrac_pkg::OP_CHECK;
      item.address      = address;
      item.region_end   = $urandom;
      item.access_size  = access_size;
      item.write_access = write_access;
      send_request(item);
   endtask

   task automatic add_region(input logic [31:0] region_start, input logic [31:0] region_end,
                             input logic [1:0] kind, input logic [2:0] perm);
      request_type item;
      item             = '0;
      item.op          = mrac_pkg::OP_INSERT;
      item.address     = region_start;
      item.region_end  = region_end;
      item.access_size = 4'($urandom_range(15, 0));
      item.region_kind = kind;
      item.can_read    = perm[mrac_pkg::PERM_READ_BIT];
      item.can_write   = perm[mrac_pkg::PERM_WRITE_BIT];
      item.can_execute = perm[mrac_pkg::PERM_EXEC_BIT];
      send_request(item);
   endtask

   task automatic send_op_only(input logic [1:0] op);
      request_type item;
      item    = '0;
      item.op = op;
      send_request(item);
   endtask

   task automatic send_noise();
      request_type item;
      item.op           = 2'($urandom_range(3, 0));
      item.address      = $urandom;
      item.region_end   = $urandom;
      item.access_size  = 4'($urandom_range(15, 0));
      item.write_access = 1'($urandom_range(1, 0));
      item.region_kind  = 2'($urandom_range(3, 0));
      item.can_read     = 1'($urandom_range(1, 0));
      item.can_write    = 1'($urandom_range(1, 0));
      item.can_execute  = 1'($urandom_range(1, 0));
      send_request(item);
   endtask

   // Holds off new requests until every outstanding response has been seen.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   // One sequence: an optional clear, a batch of inserts mostly laid out in disjoint
   // eighths of the address space, then checks aimed at those regions mixed with noise.
   task automatic run_sequence();
      int          slice_order[8];
      int          region_goal;
      int          probe_goal;
      int          pick;
      int          swap;
      logic [32:0] lo;
      logic [32:0] hi;
      logic [32:0] limit;
      logic [32:0] span;
      logic [31:0] probe;
      logic [3:0]  access_size;
      span_type    target;
      if ($urandom_range(3, 0) != 0) begin
         send_op_only(mrac_pkg::OP_CLEAR);
         layout.delete();
         sent++;
      end
      for (int k = 0; k < 8; k++) slice_order[k] = k;
      for (int k = 7; k > 0; k--) begin
         pick = $urandom_range(k, 0);
         swap = slice_order[k];
         slice_order[k] = slice_order[pick];
         slice_order[pick] = swap;
      end
      region_goal = $urandom_range(9, 1);
      for (int k = 0; k < region_goal; k++) begin
         if (layout.size() > 0 && $urandom_range(9, 0) == 0) begin
            // Deliberately collides with, or degenerates against, an earlier region.
            target = layout[$urandom_range(layout.size() - 1, 0)];
            lo = {1'b0, target.lo + 32'($urandom_range(3, 0))};
            hi = lo + 33'($urandom_range(16, 0));
         end else begin
            lo = 33'(slice_order[k % 8]) << 29;
            if ($urandom_range(3, 0) != 0) lo = lo | 33'($urandom_range(32'h1FFF_FFFF, 0));
            case ($urandom_range(3, 0))
               0:       span = 33'($urandom_range(16, 1));
               1:       span = 33'($urandom_range(4096, 17));
               2:       span = 33'($urandom_range(32'h0010_0000, 1));
               default: span = 33'h2000_0000;
            endcase
            hi = lo + span;
            limit = (33'(slice_order[k % 8]) + 33'd1) << 29;
            if (hi > limit) hi = limit;
         end
         if (hi > 33'h0_FFFF_FFFF) hi = 33'h0_FFFF_FFFF;
         add_region(lo[31:0], hi[31:0], 2'($urandom_range(3, 0)), 3'($urandom_range(7, 0)));
         layout.push_back('{lo: lo[31:0], hi: hi[31:0]});
         sent++;
      end
      probe_goal = $urandom_range(24, 4);
      for (int k = 0; k < probe_goal; k++) begin
         if ($urandom_range(9, 0) == 0 || layout.size() == 0) begin
            send_noise();
         end else begin
            target = layout[$urandom_range(layout.size() - 1, 0)];
            case ($urandom_range(3, 0))
               0:       probe = target.lo;
               1:       probe = target.hi - 32'($urandom_range(8, 1));
               2:       probe = (target.hi > target.lo) ?
                                target.lo + ($urandom % (target.hi - target.lo)) : target.lo;
               default: probe = target.hi;
            endcase
            if ($urandom_range(9, 0) < 7) access_size = 4'd1 << $urandom_range(3, 0);
            else access_size = 4'($urandom_range(15, 0));
            check_access(probe, access_size, 1'($urandom_range(1, 0)));
         end
         sent++;
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.op           <= mrac_pkg::OP_CHECK;
      req_chan.address      <= '0;
      req_chan.region_end   <= '0;
      req_chan.access_size  <= '0;
      req_chan.write_access <= 1'b0;
      req_chan.region_kind  <= KIND_RESERVED;
      req_chan.can_read     <= 1'b0;
      req_chan.can_write    <= 1'b0;
      req_chan.can_execute  <= 1'b0;
      send_gap_pct = 11;
      stall_pct    = 68;
      sent         = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every status, the table limits and the address extremes.
      check_access(32'h0000_0000, 4'd1, 1'b0);
      add_region(32'h0000_1000, 32'h0000_1000, KIND_RAM, 3'b111);
      add_region(32'h0000_2000, 32'h0000_1000, KIND_RAM, 3'b111);
      add_region(32'h0000_1000, 32'h0000_2000, KIND_RAM, 3'b111);
      add_region(32'h0000_1800, 32'h0000_2800, KIND_RAM, 3'b011);
      add_region(32'hA000_0000, 32'hA000_1000, mrac_pkg::KIND_MMIO, 3'b011);
      add_region(32'h0000_3000, 32'h0000_4000, KIND_RAM, 3'b001);
      add_region(32'h0000_4000, 32'h0000_5000, KIND_RESERVED, 3'b110);
      add_region(32'hFFFF_0000, 32'hFFFF_FFFF, KIND_SPARE, 3'b011);
      check_access(32'h0000_1000, 4'd8, 1'b1);
      check_access(32'h0000_1FFC, 4'd8, 1'b0);
      check_access(32'h0000_4000, 4'd4, 1'b0);
      check_access(32'h0000_3000, 4'd4, 1'b1);
      check_access(32'hA000_0000, 4'd3, 1'b0);
      check_access(32'hA000_0000, 4'd0, 1'b1);
      check_access(32'hA000_0002, 4'd4, 1'b0);
      check_access(32'hA000_0008, 4'd8, 1'b1);
      check_access(32'hFFFF_FFF8, 4'd15, 1'b1);
      check_access(32'hFFFF_FFFE, 4'd1, 1'b0);
      check_access(32'h0000_1003, 4'd15, 1'b0);
      send_op_only(OP_UNUSED);
      add_region(32'h0000_0000, 32'h0000_0010, mrac_pkg::KIND_MMIO, 3'b111);
      add_region(32'h0000_0010, 32'h0000_0020, KIND_RAM, 3'b000);
      add_region(32'h0000_0020, 32'h0000_0030, KIND_RAM, 3'b101);
      add_region(32'h0000_0040, 32'h0000_0050, KIND_RAM, 3'b111);
      check_access(32'hFFFF_FFFF, 4'd1, 1'b0);
      send_op_only(mrac_pkg::OP_CLEAR);
      check_access(32'h0000_1000, 4'd1, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 11;
               stall_pct    = 68;
            end
            1: begin
               send_gap_pct = 68;
               stall_pct    = 11;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
         endcase
         while (sent < (phase + 1) * RANDOM_ITEMS / 3) run_sequence();
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_total == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### memory_region_access_checker_top.f
rtl/mrac_pkg.sv
rtl/mrac_channels.sv
rtl/mrac_region_mem.sv
rtl/mrac_decide.sv
rtl/memory_region_access_checker_top.sv
tb/mrac_region_verdict_checker.sv
tb/memory_region_access_checker_top_tb.sv
